### rtl/sdwc_pkg.sv
// Shared types and constants of the sector defect window counter.
`default_nettype none
package sdwc_pkg;

    localparam int REQ_W      = 2;
    localparam int TAB_W      = 31;
    localparam int REASON_W   = 8;
    localparam int SECTOR_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [SECTOR_W-1:0] SECTOR_RESET = 16'd100;
    localparam logic [REASON_W-1:0] MIN_REASON_RESET = 8'd0;

    localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_REASON  = 2'd1;

    typedef enum logic [REQ_W-1:0] {
        REQ_JUDGE = 2'd0,
        REQ_SWEEP = 2'd1,
        REQ_CLEAR = 2'd2
    } t_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LOAD,
        ST_CHECK,
        ST_DONE
    } t_state;

endpackage
`default_nettype wire

### rtl/sdwc_in_if.sv
// Input channel carrying one tab report per beat.
`default_nettype none
interface sdwc_in_if import sdwc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [REQ_W-1:0]    req_type;
    logic [TAB_W-1:0]    tab_no;
    logic                is_defect;
    logic [REASON_W-1:0] reason_code;

    modport source (output valid, req_type, tab_no, is_defect, reason_code, input ready);
    modport sink   (input valid, req_type, tab_no, is_defect, reason_code, output ready);
endinterface
`default_nettype wire

### rtl/sdwc_out_if.sv
// Output channel carrying the window count and overflow flag per beat.
`default_nettype none
interface sdwc_out_if #(
    parameter int COUNT_W = 7
) ();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] defect_count;
    logic               overflow;

    modport source (output valid, defect_count, overflow, input ready);
    modport sink   (input valid, defect_count, overflow, output ready);
endinterface
`default_nettype wire

### rtl/sector_defect_window_counter.sv
// Top level: defect tab FIFO with a sequenced head-expiry compare unit.
// Each beat passes through EXEC and DONE; a judged tab or a sweep that finds the window non-empty
// also passes LOAD and CHECK, and a sweep stays in CHECK while it drops expired head entries.
// One item at a time; the next beat is taken only once the result of the last one is registered.
// Synchronous active-low reset clears the pointers and count and restores sector_size
// to 100 and min_reason to 0; the entry RAM is not cleared.
`default_nettype none
module sector_defect_window_counter import sdwc_pkg::*; #(
    parameter int WINDOW_DEPTH = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    sdwc_in_if.sink                    i_in,
    sdwc_out_if.source                 o_out
);

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int CW = $clog2(WINDOW_DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(WINDOW_DEPTH);
    localparam logic [AW-1:0] LAST_SLOT  = AW'(WINDOW_DEPTH - 1);

    t_state              r_state, n_state;
    logic [SECTOR_W-1:0] r_sector;
    logic [REASON_W-1:0] r_min_reason;
    t_req                r_req;
    logic [TAB_W-1:0]    r_tab;
    logic                r_defect;
    logic [REASON_W-1:0] r_reason;
    logic [AW-1:0]       r_head, n_head;
    logic [AW-1:0]       r_tail, n_tail;
    logic [CW-1:0]       r_total, n_total;
    logic                r_ovf, n_ovf;
    logic                r_out_valid, n_out_valid;
    logic [CW-1:0]       r_out_count;
    logic                r_out_ovf;
    logic                w_load_out;

    logic                w_we;
    logic [TAB_W-1:0]    w_rdata;
    logic [TAB_W:0]      w_diff;
    logic [TAB_W-1:0]    w_sector_ext;
    logic                w_lag_ge;
    logic                w_lag_gt;
    logic                w_hit;
    logic [CW:0]         w_ptr_sum;
    logic [CW:0]         w_ptr_wrap;

    function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] idx);
        return (idx == LAST_SLOT) ? '0 : idx + 1'b1;
    endfunction

    sdwc_ram #(
        .WIDTH (TAB_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_tail),
        .i_wdata (r_tab),
        .i_raddr (n_head),
        .o_rdata (w_rdata)
    );

    // Lag of the head entry as a signed difference; negative lag never expires.
    assign w_sector_ext = {{(TAB_W - SECTOR_W){1'b0}}, r_sector};
    assign w_diff   = {1'b0, r_tab} - {1'b0, w_rdata};
    assign w_lag_ge = !w_diff[TAB_W] && (w_diff[TAB_W-1:0] >= w_sector_ext);
    assign w_lag_gt = w_lag_ge && (w_diff[TAB_W-1:0] != w_sector_ext);
    assign w_hit    = (r_req == REQ_JUDGE) ? w_lag_ge : w_lag_gt;

    assign i_in.ready         = (r_state == ST_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.defect_count = r_out_count;
    assign o_out.overflow     = r_out_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sector     <= SECTOR_RESET;
            r_min_reason <= MIN_REASON_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SECTOR_SIZE: r_sector <= i_cfg_data;
                CFG_MIN_REASON:  r_min_reason <= i_cfg_data[REASON_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_total     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_total     <= n_total;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_req    <= t_req'(i_in.req_type);
            r_tab    <= i_in.tab_no;
            r_defect <= i_in.is_defect;
            r_reason <= i_in.reason_code;
        end
        if (w_load_out) begin
            r_out_count <= r_total;
            r_out_ovf   <= r_ovf;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_total     = r_total;
        n_ovf       = r_ovf;
        w_we        = 1'b0;
        w_load_out  = 1'b0;
        n_out_valid = r_out_valid && !o_out.ready;
        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) begin
                    n_state = ST_EXEC;
                    n_ovf   = 1'b0;
                end
            end
            ST_EXEC: begin
                case (r_req)
                    REQ_JUDGE: begin
                        if (r_defect && (r_reason >= r_min_reason)) begin
                            if (r_total == FULL_COUNT) begin
                                n_ovf = 1'b1;
                            end else begin
                                w_we    = 1'b1;
                                n_tail  = next_slot(r_tail);
                                n_total = r_total + 1'b1;
                            end
                        end
                        n_state = (n_total != '0) ? ST_LOAD : ST_DONE;
                    end
                    REQ_SWEEP: begin
                        n_state = (r_total != '0) ? ST_LOAD : ST_DONE;
                    end
                    REQ_CLEAR: begin
                        n_head  = '0;
                        n_tail  = '0;
                        n_total = '0;
                        n_state = ST_DONE;
                    end
                    default: begin
                        n_state = ST_DONE;
                    end
                endcase
            end
            ST_LOAD: begin
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (w_hit) begin
                    n_head  = next_slot(r_head);
                    n_total = r_total - 1'b1;
                end
                if (w_hit && (r_req == REQ_SWEEP) && (r_total > CW'(1))) begin
                    n_state = ST_CHECK;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    w_load_out  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign w_ptr_sum  = {1'b0, CW'(r_head)} + {1'b0, r_total};
    assign w_ptr_wrap = (w_ptr_sum >= (CW + 1)'(WINDOW_DEPTH))
                      ? w_ptr_sum - (CW + 1)'(WINDOW_DEPTH) : w_ptr_sum;

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= FULL_COUNT)
        else $error("window count exceeds store depth");

    a_ptr_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ptr_wrap[AW-1:0] == r_tail)
        else $error("tail pointer does not match head plus count");

    a_check_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CHECK) |-> (r_total != '0))
        else $error("head compare on an empty window");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC && r_req == REQ_CLEAR) |=> (r_total == '0))
        else $error("clear request left entries in the window");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.overflow) |-> (o_out.defect_count >= FULL_COUNT - 1'b1))
        else $error("overflow flagged while the store was not full");

endmodule
`default_nettype wire

### rtl/sdwc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sdwc_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire
